// ===== hdl/stack_machine_execute_unit_macros.svh =====
// Assertion macros for the stack machine execute unit.
// Each macro checks an implication on the rising clock edge, disabled in reset.
`ifndef STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH
`define STACK_MACHINE_EXECUTE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SME_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SME_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SME_ASSERT_SAME(label, clk, rst, ante, cons)
`define SME_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hdl/sme_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute unit package
// Opcodes, status codes, controller states and control structures.
// ----------------------------------------------------------------------------
package sme_pkg;

   localparam int DATA_W   = 32;
   localparam int FUNC_W   = 4;
   localparam int PLEN_W   = 31;
   localparam int STATUS_W = 3;

   localparam logic [FUNC_W-1:0] OP_NOP  = 4'd0;
   localparam logic [FUNC_W-1:0] OP_PUSH = 4'd1;
   localparam logic [FUNC_W-1:0] OP_POP  = 4'd2;
   localparam logic [FUNC_W-1:0] OP_DUP  = 4'd3;
   localparam logic [FUNC_W-1:0] OP_ADD  = 4'd4;
   localparam logic [FUNC_W-1:0] OP_SUB  = 4'd5;
   localparam logic [FUNC_W-1:0] OP_MUL  = 4'd6;
   localparam logic [FUNC_W-1:0] OP_DIV  = 4'd7;
   localparam logic [FUNC_W-1:0] OP_JMP  = 4'd8;
   localparam logic [FUNC_W-1:0] OP_JNZ  = 4'd9;
   localparam logic [FUNC_W-1:0] OP_EQL  = 4'd10;
   localparam logic [FUNC_W-1:0] OP_HLT  = 4'd11;

   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_IP      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_OVER    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DIVZ    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_OPERAND = 3'd5;
   localparam logic [STATUS_W-1:0] ST_OPCODE  = 3'd6;

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_RD_TOP  = 6'b000010,
      S_RD_SEC  = 6'b000100,
      S_EXEC    = 6'b001000,
      S_DIV     = 6'b010000,
      S_COMMIT  = 6'b100000
   } state_type;

   typedef struct packed {
      logic load;
      logic rd_top;
      logic rd_second;
      logic exec;
      logic div_start;
      logic div_capture;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic div_go;
      logic div_done;
      logic out_free;
   } stat_type;

endpackage

// ===== hdl/sme_divider.sv =====
// ----------------------------------------------------------------------------
// Stack machine iterative divider
// Signed truncating division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sme_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [sme_pkg::DATA_W-1:0] dividend,
   input  logic [sme_pkg::DATA_W-1:0] divisor,
   output logic                      done,
   output logic [sme_pkg::DATA_W-1:0] quotient
);
   import sme_pkg::*;

   localparam int CNT_W = $clog2(DATA_W);

   logic [DATA_W-1:0] rem_ff, rem_in, quo_ff, quo_in, dsr_ff, dsr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic [DATA_W:0]   shifted, diff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[DATA_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend[DATA_W-1] ? -dividend : dividend;
         dsr_in  = divisor[DATA_W-1] ? -divisor : divisor;
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DATA_W]) begin
            rem_in = diff[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -quo_ff : quo_ff;

endmodule

// ===== hdl/sme_datapath.sv =====
// ----------------------------------------------------------------------------
// Stack machine datapath
// Stack memory, machine registers, arithmetic and the result register.
// ----------------------------------------------------------------------------
module sme_datapath #(
   parameter int STACK_DEPTH = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sme_pkg::cmd_type            cmd,
   output sme_pkg::stat_type           stat,
   input  logic [sme_pkg::FUNC_W-1:0]   in_func,
   input  logic [sme_pkg::DATA_W-1:0]   in_operand,
   input  logic                        csr_wen,
   input  logic [sme_pkg::PLEN_W-1:0]   csr_wdata,
   input  logic                        out_ready,
   output logic                        out_valid,
   output logic [sme_pkg::STATUS_W-1:0] out_status,
   output logic [sme_pkg::DATA_W-1:0]   out_next_ip,
   output logic                        out_halted,
   output logic                        out_print_valid,
   output logic [sme_pkg::DATA_W-1:0]   out_print_value
);
   import sme_pkg::*;

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int DW = $clog2(STACK_DEPTH + 1);

   logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];
   logic [DATA_W-1:0]   rd_data_ff, top_ff, res_ff, res_in, operand_ff;
   logic [FUNC_W-1:0]   func_ff;
   logic [PLEN_W-1:0]   plen_ff;
   logic [DW-1:0]       depth_ff, depth_in;
   logic [DATA_W-1:0]   ip_ff, ip_in;
   logic                halt_ff, halt_in;
   logic [STATUS_W-1:0] status_ff, status_c;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [DATA_W-1:0]   rsp_ip_ff, rsp_pval_ff, pval_in;
   logic                rsp_halt_ff, rsp_pv_ff, pv_in;
   logic                mem_re, mem_we, is_binop, ok;
   logic [AW-1:0]       rd_addr, wr_addr;
   logic [DATA_W-1:0]   wr_data, dup_addr, div_quot, product;
   logic [DW-1:0]       depth_m1, depth_m2;
   logic                div_done;

   assign is_binop = func_ff inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQL};
   assign depth_m1 = depth_ff - DW'(1);
   assign depth_m2 = depth_ff - DW'(2);
   assign dup_addr = DATA_W'(depth_ff) - operand_ff;
   assign ok       = (status_ff == ST_OK);

   always_comb begin
      mem_re  = cmd.rd_top | cmd.rd_second;
      rd_addr = depth_m2[AW-1:0];
      if (cmd.rd_top) begin
         rd_addr = (func_ff == OP_DUP) ? dup_addr[AW-1:0] : depth_m1[AW-1:0];
      end
   end

   always_comb begin
      status_c = ST_OK;
      if (ip_ff >= {1'b0, plen_ff}) begin
         status_c = ST_IP;
      end else begin
         case (func_ff)
            OP_NOP, OP_JMP, OP_HLT: status_c = ST_OK;
            OP_PUSH: if (depth_ff >= DW'(STACK_DEPTH)) status_c = ST_OVER;
            OP_POP, OP_JNZ: if (depth_ff == '0) status_c = ST_UNDER;
            OP_DUP: begin
               if (depth_ff >= DW'(STACK_DEPTH)) status_c = ST_OVER;
               else if (operand_ff == '0 || operand_ff[DATA_W-1]) status_c = ST_OPERAND;
               else if (operand_ff > DATA_W'(depth_ff)) status_c = ST_UNDER;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQL: begin
               if (depth_ff < DW'(2)) status_c = ST_UNDER;
               else if (func_ff == OP_DIV && top_ff == '0) status_c = ST_DIVZ;
            end
            default: status_c = ST_OPCODE;
         endcase
      end
   end

   assign product = rd_data_ff * top_ff;

   always_comb begin
      case (func_ff)
         OP_ADD:  res_in = rd_data_ff + top_ff;
         OP_SUB:  res_in = rd_data_ff - top_ff;
         OP_MUL:  res_in = product;
         default: res_in = {{(DATA_W-1){1'b0}}, rd_data_ff == top_ff};
      endcase
   end

   sme_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (rd_data_ff),
      .divisor  (top_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      depth_in = depth_ff;
      ip_in    = ip_ff;
      halt_in  = halt_ff;
      pv_in    = 1'b0;
      pval_in  = '0;
      mem_we   = 1'b0;
      wr_addr  = depth_ff[AW-1:0];
      wr_data  = res_ff;
      if (ok) begin
         ip_in = ip_ff + DATA_W'(1);
         case (func_ff)
            OP_PUSH: begin
               mem_we   = 1'b1;
               wr_data  = operand_ff;
               depth_in = depth_ff + DW'(1);
            end
            OP_DUP: begin
               mem_we   = 1'b1;
               wr_data  = top_ff;
               depth_in = depth_ff + DW'(1);
            end
            OP_POP: begin
               depth_in = depth_m1;
               pv_in    = 1'b1;
               pval_in  = top_ff;
            end
            OP_JMP: ip_in = operand_ff;
            OP_JNZ: begin
               if (top_ff != '0) begin
                  depth_in = depth_m1;
                  ip_in    = operand_ff;
               end
            end
            OP_HLT: begin
               halt_in = 1'b1;
               ip_in   = ip_ff;
            end
            default: begin
               if (is_binop) begin
                  mem_we   = 1'b1;
                  wr_addr  = depth_m2[AW-1:0];
                  depth_in = depth_m1;
               end
            end
         endcase
      end else begin
         ip_in = ip_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && mem_we) begin
         stack_mem[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff    <= in_func;
         operand_ff <= in_operand;
      end
      if (cmd.rd_second) begin
         top_ff <= rd_data_ff;
      end
      if (cmd.exec) begin
         status_ff <= status_c;
         res_ff    <= res_in;
      end else if (cmd.div_capture) begin
         res_ff <= div_quot;
      end
      if (cmd.commit) begin
         rsp_status_ff <= status_ff;
         rsp_ip_ff     <= ip_in;
         rsp_halt_ff   <= halt_in;
         rsp_pv_ff     <= pv_in;
         rsp_pval_ff   <= pval_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         ip_ff        <= '0;
         halt_ff      <= 1'b0;
         plen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            plen_ff <= csr_wdata;
         end
         if (cmd.commit) begin
            depth_ff     <= depth_in;
            ip_ff        <= ip_in;
            halt_ff      <= halt_in;
            rsp_valid_ff <= 1'b1;
         end else if (out_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.div_go   = (func_ff == OP_DIV) && (status_c == ST_OK);
   assign stat.div_done = div_done;
   assign stat.out_free = !rsp_valid_ff || out_ready;

   assign out_valid       = rsp_valid_ff;
   assign out_status      = rsp_status_ff;
   assign out_next_ip     = rsp_ip_ff;
   assign out_halted      = rsp_halt_ff;
   assign out_print_valid = rsp_pv_ff;
   assign out_print_value = rsp_pval_ff;

endmodule

// ===== hdl/sme_controller.sv =====
// ----------------------------------------------------------------------------
// Stack machine controller
// Sequences operand reads, execution, division and commit of one instruction.
// ----------------------------------------------------------------------------
module sme_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  sme_pkg::stat_type stat,
   output sme_pkg::cmd_type  cmd
);
   import sme_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      in_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = S_RD_TOP;
            end
         end
         S_RD_TOP: begin
            cmd.rd_top = 1'b1;
            state_in   = S_RD_SEC;
         end
         S_RD_SEC: begin
            cmd.rd_second = 1'b1;
            state_in      = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (stat.div_go) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_DIV: begin
            if (stat.div_done) begin
               cmd.div_capture = 1'b1;
               state_in        = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/stack_machine_execute_unit.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute unit
// Each transaction on the request channel carries one instruction, fetched at
// the instruction pointer of the previous response, and produces exactly one
// response transaction with the status, the next instruction pointer, the halt
// flag and any value removed by pop. Instructions are handled one at a time:
// most pass through the two registered reads of the stack memory, the execute
// step and the commit, which loads the response register, and the next
// instruction is accepted in the cycle after the commit. Division adds a wait
// for the divider between the execute step and the commit, as the divider
// produces one quotient bit per cycle. The commit waits while an earlier
// response is still held, which also holds off the request channel. The
// program length register may be written only while the unit is idle.
// ----------------------------------------------------------------------------
`include "stack_machine_execute_unit_macros.svh"

module stack_machine_execute_unit #(
   parameter int STACK_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // func[3:0], operand[35:4], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // status[2:0], next_ip[34:3], halted[35],
                                    // print_valid[36], print_value[68:37]
   input  logic        csr_wen,
   input  logic [30:0] csr_wdata
);
   import sme_pkg::*;

   cmd_type             cmd;
   stat_type            stat;
   logic [STATUS_W-1:0] out_status;
   logic [DATA_W-1:0]   out_next_ip, out_print_value;
   logic                out_halted, out_print_valid;

   sme_controller u_controller (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .stat     (stat),
      .cmd      (cmd)
   );

   sme_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .in_func         (req_tdata[3:0]),
      .in_operand      (req_tdata[35:4]),
      .csr_wen         (csr_wen),
      .csr_wdata       (csr_wdata),
      .out_ready       (rsp_tready),
      .out_valid       (rsp_tvalid),
      .out_status      (out_status),
      .out_next_ip     (out_next_ip),
      .out_halted      (out_halted),
      .out_print_valid (out_print_valid),
      .out_print_value (out_print_value)
   );

   assign rsp_tdata = {3'b000, out_print_value, out_print_valid, out_halted,
                       out_next_ip, out_status};

   `SME_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `SME_ASSERT_NEXT(a_commit_shows_result, clock, reset, cmd.commit, rsp_tvalid)
   `SME_ASSERT_SAME(a_div_not_commit, clock, reset, cmd.div_start, !cmd.commit && !req_tready)

endmodule

// ===== verif/stack_machine_execute_unit_checker.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute unit checker
// Watches the instruction and response channels and the program length
// writes, runs its own model of the machine state for every accepted
// instruction, and compares each response with the oldest expected one.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit_checker #(
   parameter int STACK_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic [30:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import sme_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0]   print_value;
      logic                print_valid;
      logic                halted;
      logic [DATA_W-1:0]   next_ip;
      logic [STATUS_W-1:0] status;
   } outcome_type;

   logic [DATA_W-1:0] mach_stack [STACK_DEPTH];
   int unsigned       mach_depth;
   logic [DATA_W-1:0] mach_ip;
   logic              mach_halt;
   logic [PLEN_W-1:0] mach_plen;
   outcome_type       outcome_queue [$];

   function automatic logic [DATA_W-1:0] alu_result(logic [FUNC_W-1:0] op,
                                                    logic [DATA_W-1:0] a,
                                                    logic [DATA_W-1:0] b);
      logic signed [DATA_W-1:0] sa, sb;
      sa = a;
      sb = b;
      case (op)
         OP_ADD:  return a + b;
         OP_SUB:  return a - b;
         OP_MUL:  return a * b;
         OP_DIV: begin
            if (sa == 32'sh8000_0000 && sb == -32'sd1) return a;
            return sa / sb;
         end
         default: return (a == b) ? 32'd1 : 32'd0;
      endcase
   endfunction

   function automatic outcome_type execute_instruction(logic [FUNC_W-1:0] op,
                                                       logic [DATA_W-1:0] arg);
      outcome_type       o;
      logic [DATA_W-1:0] nxt;
      o = '0;
      o.status = ST_OK;
      nxt = mach_ip + 32'd1;
      if ({1'b0, mach_ip} >= {2'b0, mach_plen}) begin
         o.status = ST_IP;
      end else begin
         case (op)
            OP_NOP: ;
            OP_PUSH: begin
               if (mach_depth >= STACK_DEPTH) o.status = ST_OVER;
               else begin
                  mach_stack[mach_depth] = arg;
                  mach_depth++;
               end
            end
            OP_POP: begin
               if (mach_depth < 1) o.status = ST_UNDER;
               else begin
                  mach_depth--;
                  o.print_valid = 1'b1;
                  o.print_value = mach_stack[mach_depth];
               end
            end
            OP_DUP: begin
               if (mach_depth >= STACK_DEPTH) o.status = ST_OVER;
               else if (arg == 0 || arg[31]) o.status = ST_OPERAND;
               else if (arg > mach_depth) o.status = ST_UNDER;
               else begin
                  mach_stack[mach_depth] = mach_stack[mach_depth - arg];
                  mach_depth++;
               end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQL: begin
               if (mach_depth < 2) o.status = ST_UNDER;
               else if (op == OP_DIV && mach_stack[mach_depth-1] == 0) o.status = ST_DIVZ;
               else begin
                  mach_stack[mach_depth-2] = alu_result(op, mach_stack[mach_depth-2],
                                                        mach_stack[mach_depth-1]);
                  mach_depth--;
               end
            end
            OP_JMP: nxt = arg;
            OP_JNZ: begin
               if (mach_depth < 1) o.status = ST_UNDER;
               else if (mach_stack[mach_depth-1] != 0) begin
                  mach_depth--;
                  nxt = arg;
               end
            end
            OP_HLT: begin
               mach_halt = 1'b1;
               nxt = mach_ip;
            end
            default: o.status = ST_OPCODE;
         endcase
         if (o.status == ST_OK) mach_ip = nxt;
      end
      o.next_ip = mach_ip;
      o.halted = mach_halt;
      return o;
   endfunction

   assign pending_count = outcome_queue.size();

   always @(posedge clock) begin
      outcome_type got, want;
      if (reset) begin
         mach_depth = 0;
         mach_ip = '0;
         mach_halt = 1'b0;
         mach_plen = '0;
         outcome_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_wen) mach_plen = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[68:0];
            if (outcome_queue.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h", $time, got);
               fail_count++;
            end else begin
               want = outcome_queue.pop_front();
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                  fail_count++;
               end
               if (got.next_ip !== want.next_ip) begin
                  $display("%0t: next_ip expected %h actual %h", $time, want.next_ip,
                           got.next_ip);
                  fail_count++;
               end
               if (got.halted !== want.halted) begin
                  $display("%0t: halted expected %b actual %b", $time, want.halted, got.halted);
                  fail_count++;
               end
               if (got.print_valid !== want.print_valid) begin
                  $display("%0t: print_valid expected %b actual %b", $time, want.print_valid,
                           got.print_valid);
                  fail_count++;
               end
               if (got.print_value !== want.print_value) begin
                  $display("%0t: print_value expected %h actual %h", $time, want.print_value,
                           got.print_value);
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            outcome_queue.push_back(execute_instruction(req_tdata[3:0], req_tdata[35:4]));
      end
   end
endmodule

// ===== verif/stack_machine_execute_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute unit testbench
// Drives directed and random instruction streams through several program
// length settings and idling phases, including a long response hold-off, and
// reports the verdict of the checker.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sme_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam logic [FUNC_W-1:0] OP_ILLEGAL_LO = 4'd12;
   localparam logic [FUNC_W-1:0] OP_ILLEGAL_HI = 4'd15;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        csr_wen = 1'b0;
   logic [30:0] csr_wdata = '0;
   int          fail_count;
   int          pending_count;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          holdoff_cycles = 0;
   int          cycle_count = 0;

   stack_machine_execute_unit u_dut (.*);

   stack_machine_execute_unit_checker u_checker (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Response side: random stalls, plus a long hold-off on request.
   always @(negedge clock) begin
      if (holdoff_cycles > 0) begin
         holdoff_cycles <= holdoff_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_instruction(logic [FUNC_W-1:0] op, logic [DATA_W-1:0] arg);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, arg, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_and_set_length(logic [30:0] plen);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= plen;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   function automatic logic [DATA_W-1:0] random_value();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'd0;
         4: return $urandom_range(7);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_instruction(bit wild);
      logic [FUNC_W-1:0] op;
      logic [DATA_W-1:0] arg;
      op = wild ? FUNC_W'($urandom_range(15)) : FUNC_W'($urandom_range(11));
      if (!wild && op != OP_PUSH && $urandom_range(2) == 0) op = OP_PUSH;
      case (op)
         OP_DUP: arg = ($urandom_range(9) == 0) ? random_value() : $urandom_range(1, 6);
         OP_JMP, OP_JNZ: arg = ($urandom_range(9) == 0) ? random_value()
                                                         : $urandom_range(0, 60);
         default: arg = random_value();
      endcase
      send_instruction(op, arg);
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      // Zero length: every instruction is out of range.
      send_instruction(OP_PUSH, 32'd5);
      drain_and_set_length(31'h7fff_ffff);
      send_instruction(OP_POP, 0);
      send_instruction(OP_ADD, 0);
      send_instruction(OP_JNZ, 0);
      send_instruction(OP_DUP, 1);
      send_instruction(OP_PUSH, 32'h8000_0000);
      send_instruction(OP_PUSH, 32'hffff_ffff);
      send_instruction(OP_DIV, 0);
      send_instruction(OP_PUSH, 32'h7fff_ffff);
      send_instruction(OP_DUP, 0);
      send_instruction(OP_DUP, 32'h8000_0000);
      send_instruction(OP_DUP, 3);
      send_instruction(OP_DUP, 4);
      send_instruction(OP_PUSH, 0);
      send_instruction(OP_DIV, 0);
      send_instruction(OP_JNZ, 7);
      send_instruction(OP_POP, 0);
      send_instruction(OP_SUB, 0);
      send_instruction(OP_MUL, 0);
      send_instruction(OP_EQL, 0);
      send_instruction(OP_ILLEGAL_LO, 0);
      send_instruction(OP_ILLEGAL_HI, 32'hffff_ffff);
      send_instruction(OP_HLT, 0);
      send_instruction(OP_NOP, 0);
      send_instruction(OP_JNZ, 32'd2);
      send_instruction(OP_NOP, 0);
      send_instruction(OP_JMP, 32'd3);
      // Fill the stack to overflow, with a long hold-off on responses.
      holdoff_cycles = 300;
      repeat (258) send_instruction(OP_PUSH, $urandom);
      send_instruction(OP_DUP, 1);
      repeat (258) send_instruction(OP_POP, 0);
      drain_and_set_length(31'd40);
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 48 : 6) : 0;
         stall_pct = (phase == 2) ? 48 : ((phase == 3) ? 6 : 0);
         repeat (25) random_instruction($urandom_range(9) == 0);
         drain_and_set_length((phase == 2) ? 31'd1 : 31'($urandom_range(20, 64)));
      end
      send_idle_pct = 0;
      stall_pct = 0;
      repeat (10) random_instruction(1'b0);
      // A jump to a negative address faults on the following instruction.
      send_instruction(OP_JMP, 32'hffff_fff0);
      send_instruction(OP_NOP, 0);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
